[rtl/qat_pkg.sv]
// qat_pkg: shared types and constants of the quoted argument tokenizer
// depends on nothing; used by every rtl file of the block but qat_ram
`default_nettype none

package qat_pkg;

  localparam int unsigned LIMIT_W  = 5;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned START_W  = 12;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CNT_W    = 5;

  localparam logic [7:0] CHAR_SPACE  = 8'd32;
  localparam logic [7:0] CHAR_DQUOTE = 8'd34;
  localparam logic [7:0] CHAR_SQUOTE = 8'd39;
  localparam logic [7:0] CHAR_LOW    = 8'd33;
  localparam logic [7:0] CHAR_HIGH   = 8'd126;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_TOO_MANY = 3'd1,
    ST_INVALID  = 3'd2,
    ST_UNCLOSED = 3'd3,
    ST_TOO_LONG = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CLS_NORMAL  = 2'd0,
    CLS_QUOTE   = 2'd1,
    CLS_SPACE   = 2'd2,
    CLS_INVALID = 2'd3
  } cls_e;

  typedef struct packed {
    logic is_end;
    cls_e cls;
  } tok_t;

  typedef struct packed {
    logic                is_summary;
    logic [IDX_W-1:0]    arg_index;
    logic [START_W-1:0]  arg_start;
    logic [LEN_W-1:0]    arg_length;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    arg_count;
    logic                last;
  } res_t;

endpackage

`default_nettype wire

[rtl/qat_if.sv]
// qat_if: valid/ready channel interfaces of the tokenizer
// depends on qat_pkg for field widths
`default_nettype none

interface qat_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_byte;
  modport source (output valid, req_type, char_byte, input ready);
  modport sink (input valid, req_type, char_byte, output ready);
endinterface

interface qat_out_if;
  logic                          valid;
  logic                          ready;
  logic                          is_summary;
  logic [qat_pkg::IDX_W-1:0]     arg_index;
  logic [qat_pkg::START_W-1:0]   arg_start;
  logic [qat_pkg::LEN_W-1:0]     arg_length;
  logic [qat_pkg::STATUS_W-1:0]  status;
  logic [qat_pkg::CNT_W-1:0]     arg_count;
  logic                          last;
  modport source (output valid, is_summary, arg_index, arg_start, arg_length, status,
                  arg_count, last, input ready);
  modport sink (input valid, is_summary, arg_index, arg_start, arg_length, status,
                arg_count, last, output ready);
endinterface

interface qat_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [qat_pkg::LIMIT_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

[rtl/qat_ram.sv]
// qat_ram: generic single write port ram with registered read
// no dependencies
`default_nettype none

module qat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/qat_front.sv]
// qat_front: accepts input transactions, classifies the byte and queues the token
// depends on qat_pkg
`default_nettype none

module qat_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          req_type_i,
  input  wire logic [7:0]    char_byte_i,
  output logic               tok_valid_o,
  input  wire logic          tok_ready_i,
  output qat_pkg::tok_t      tok_o
);

  qat_pkg::tok_t tok_mem_q [2];
  qat_pkg::tok_t new_tok;
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          push, pop;

  always_comb begin
    new_tok.is_end = req_type_i;
    if (char_byte_i == qat_pkg::CHAR_SPACE) begin
      new_tok.cls = qat_pkg::CLS_SPACE;
    end else if (char_byte_i == qat_pkg::CHAR_SQUOTE ||
                 char_byte_i == qat_pkg::CHAR_DQUOTE) begin
      new_tok.cls = qat_pkg::CLS_QUOTE;
    end else if (char_byte_i inside {[qat_pkg::CHAR_LOW:qat_pkg::CHAR_HIGH]}) begin
      new_tok.cls = qat_pkg::CLS_NORMAL;
    end else begin
      new_tok.cls = qat_pkg::CLS_INVALID;
    end
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign tok_valid_o = (cnt_q != 2'd0);
  assign tok_o       = tok_mem_q[rd_ptr_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = tok_valid_o & tok_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      tok_mem_q[wr_ptr_q] <= new_tok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/qat_back.sv]
// qat_back: tokenizer state, argument table and result drain with output register
// depends on qat_pkg and qat_ram
`default_nettype none

module qat_back #(
  parameter int unsigned MAX_ARGS         = 16,
  parameter int unsigned MAX_STRING_BYTES = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [qat_pkg::LIMIT_W-1:0]   arg_limit_i,
  input  wire logic                          tok_valid_i,
  output logic                               tok_ready_o,
  input  wire qat_pkg::tok_t                 tok_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output qat_pkg::res_t                      out_o
);

  localparam int unsigned FoundW = $clog2(MAX_ARGS + 1);
  localparam int unsigned AddrW  = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
  localparam int unsigned PosW   = $clog2(MAX_STRING_BYTES + 1);
  localparam int unsigned CmpW   = (FoundW > qat_pkg::LIMIT_W) ? FoundW : qat_pkg::LIMIT_W;
  localparam int unsigned EntW   = qat_pkg::START_W + qat_pkg::LEN_W;
  localparam logic [PosW-1:0] PosMax  = PosW'(MAX_STRING_BYTES);
  localparam logic [CmpW-1:0] ArgsMax = CmpW'(MAX_ARGS);

  typedef enum logic [3:0] {
    S_RUN  = 4'b0001,
    S_READ = 4'b0010,
    S_LOAD = 4'b0100,
    S_SUM  = 4'b1000
  } state_e;

  state_e                        state_q, state_d;
  logic                          in_arg_q, in_arg_d;
  logic                          quoting_q, quoting_d;
  logic [FoundW-1:0]             found_q, found_d;
  logic [FoundW-1:0]             idx_q, idx_d;
  logic [PosW-1:0]               pos_q, pos_d;
  qat_pkg::status_e              err_q, err_d;
  logic [qat_pkg::START_W-1:0]   cur_start_q, cur_start_d;
  logic [qat_pkg::LEN_W-1:0]     cur_len_q, cur_len_d;
  logic                          out_valid_q, out_valid_d;
  qat_pkg::res_t                 out_q, out_d;

  logic                          ram_we, ram_re;
  logic [EntW-1:0]               ram_rdata;
  logic [CmpW-1:0]               lim_ext, eff_lim;
  logic                          pop, out_free, is_normal, is_quote, is_space;
  logic [FoundW-1:0]             idx_next;

  assign tok_ready_o = (state_q == S_RUN);
  assign pop         = tok_valid_i & tok_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign lim_ext     = CmpW'(arg_limit_i);
  assign eff_lim     = (lim_ext > ArgsMax) ? ArgsMax : lim_ext;
  assign is_normal   = (tok_i.cls == qat_pkg::CLS_NORMAL);
  assign is_quote    = (tok_i.cls == qat_pkg::CLS_QUOTE);
  assign is_space    = (tok_i.cls == qat_pkg::CLS_SPACE);
  assign idx_next    = idx_q + FoundW'(1);
  assign ram_re      = (state_q == S_READ);

  qat_ram #(
    .Width(EntW),
    .Depth(MAX_ARGS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(found_q[AddrW-1:0]),
    .wdata_i({cur_start_q, cur_len_q}),
    .re_i   (ram_re),
    .raddr_i(idx_q[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    in_arg_d    = in_arg_q;
    quoting_d   = quoting_q;
    found_d     = found_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    err_d       = err_q;
    cur_start_d = cur_start_q;
    cur_len_d   = cur_len_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;

    case (state_q)
      S_RUN: begin
        if (pop && !tok_i.is_end) begin
          if (err_q != qat_pkg::ST_OK) begin
            err_d = err_q;
          end else if (pos_q >= PosMax) begin
            err_d = qat_pkg::ST_TOO_LONG;
          end else if (tok_i.cls == qat_pkg::CLS_INVALID) begin
            err_d = qat_pkg::ST_INVALID;
          end else if (!in_arg_q) begin
            if (!is_space && CmpW'(found_q) >= eff_lim) begin
              err_d = qat_pkg::ST_TOO_MANY;
            end else begin
              if (!is_space) begin
                cur_start_d = is_normal ? qat_pkg::START_W'(pos_q)
                                        : qat_pkg::START_W'(pos_q + PosW'(1));
                cur_len_d   = is_normal ? qat_pkg::LEN_W'(1) : qat_pkg::LEN_W'(0);
                in_arg_d    = 1'b1;
                quoting_d   = is_quote;
              end
              pos_d = pos_q + PosW'(1);
            end
          end else begin
            if (is_normal || (is_space && quoting_q)) begin
              cur_len_d = cur_len_q + qat_pkg::LEN_W'(1);
            end else begin
              ram_we    = 1'b1;
              in_arg_d  = 1'b0;
              quoting_d = 1'b0;
              found_d   = found_q + FoundW'(1);
            end
            pos_d = pos_q + PosW'(1);
          end
        end else if (pop) begin
          if (err_q == qat_pkg::ST_OK && in_arg_q) begin
            if (quoting_q) begin
              err_d = qat_pkg::ST_UNCLOSED;
            end else begin
              ram_we  = 1'b1;
              found_d = found_q + FoundW'(1);
            end
          end
          idx_d = '0;
          if (err_d == qat_pkg::ST_OK && found_d != '0) begin
            state_d = S_READ;
          end else begin
            state_d = S_SUM;
          end
        end
      end
      S_READ: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.is_summary = 1'b0;
          out_d.arg_index  = qat_pkg::IDX_W'(idx_q);
          out_d.arg_start  = ram_rdata[EntW-1:qat_pkg::LEN_W];
          out_d.arg_length = ram_rdata[qat_pkg::LEN_W-1:0];
          out_d.status     = qat_pkg::ST_OK;
          out_d.arg_count  = '0;
          out_d.last       = 1'b0;
          idx_d            = idx_next;
          state_d          = (idx_next == found_q) ? S_SUM : S_READ;
        end
      end
      S_SUM: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.is_summary = 1'b1;
          out_d.arg_index  = '0;
          out_d.arg_start  = '0;
          out_d.arg_length = '0;
          out_d.status     = err_q;
          out_d.arg_count  = (err_q == qat_pkg::ST_OK) ? qat_pkg::CNT_W'(found_q) : '0;
          out_d.last       = 1'b1;
          in_arg_d         = 1'b0;
          quoting_d        = 1'b0;
          found_d          = '0;
          pos_d            = '0;
          err_d            = qat_pkg::ST_OK;
          state_d          = S_RUN;
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_start_q <= cur_start_d;
    cur_len_q   <= cur_len_d;
    out_q       <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      in_arg_q    <= 1'b0;
      quoting_q   <= 1'b0;
      found_q     <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      err_q       <= qat_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_arg_q    <= in_arg_d;
      quoting_q   <= quoting_d;
      found_q     <= found_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

[rtl/quoted_argument_tokenizer_core.sv]
// quoted_argument_tokenizer_core: top level of the quoted argument tokenizer
// depends on qat_pkg, qat_if, qat_front, qat_back and qat_ram
`default_nettype none

// Splits a byte stream into arguments. Character bytes are taken one per cycle while the
// queue has room: the front stage classifies each byte into a two entry queue and the back
// stage updates the argument state for each byte. At the end marker the back stage reads the
// argument table through its single ram read port, each argument descriptor in a read state
// and a load state, then sends the summary transaction; the queue still takes up to two
// transactions during that drain and then holds off input. The arg_limit register is always
// writable and should only be changed while the block is idle.

module quoted_argument_tokenizer_core #(
  parameter int unsigned MAX_ARGS         = 16,
  parameter int unsigned MAX_STRING_BYTES = 4096
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  qat_in_if.sink     in_i,
  qat_cfg_if.sink    cfg_i,
  qat_out_if.source  out_o
);

  logic [qat_pkg::LIMIT_W-1:0] arg_limit_q;
  logic                        tok_valid, tok_ready;
  qat_pkg::tok_t               tok;
  qat_pkg::res_t               res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arg_limit_q <= qat_pkg::LIMIT_RESET;
    end else if (cfg_i.valid) begin
      arg_limit_q <= cfg_i.data;
    end
  end

  qat_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .req_type_i (in_i.req_type),
    .char_byte_i(in_i.char_byte),
    .tok_valid_o(tok_valid),
    .tok_ready_i(tok_ready),
    .tok_o      (tok)
  );

  qat_back #(
    .MAX_ARGS        (MAX_ARGS),
    .MAX_STRING_BYTES(MAX_STRING_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .arg_limit_i(arg_limit_q),
    .tok_valid_i(tok_valid),
    .tok_ready_o(tok_ready),
    .tok_i      (tok),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .out_o      (res)
  );

  assign out_o.is_summary = res.is_summary;
  assign out_o.arg_index  = res.arg_index;
  assign out_o.arg_start  = res.arg_start;
  assign out_o.arg_length = res.arg_length;
  assign out_o.status     = res.status;
  assign out_o.arg_count  = res.arg_count;
  assign out_o.last       = res.last;

endmodule

`default_nettype wire
